// File: rtl/core/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants for the grid line-of-sight unit
// Map geometry, fixed-point widths and the beat structs of both channels.
// ----------------------------------------------------------------------------
package gls_pkg;

	// Grid and fixed-point geometry
	localparam int GRID_BITS = 6;
	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 14;
	localparam int CELL_W    = COORD_W - FRAC_BITS;
	localparam int MAP_SIDE  = (GRID_BITS < 6) ? (1 << GRID_BITS) : 64;
	localparam int ROW_W     = $clog2(MAP_SIDE);
	localparam int MAP_W     = 64;
	localparam int ROW_IDX_W = 6;
	localparam int FRAC_ONE  = 1 << FRAC_BITS;

	// Walk position may leave the map by up to the move bound on either side
	localparam int POS_W   = CELL_W + 3;
	localparam int WALK_W  = 8;
	localparam int NDIST_W = FRAC_BITS + CELL_W + 2;
	localparam int PROD_W  = NDIST_W + COORD_W;

	// Item kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [ROW_IDX_W-1:0] map_row;
		logic [MAP_W-1:0]     row_bits;
		logic [COORD_W-1:0]   start_x;
		logic [COORD_W-1:0]   start_z;
		logic [COORD_W-1:0]   end_x;
		logic [COORD_W-1:0]   end_z;
	} gls_in_t;

	typedef struct packed {
		logic              visible;
		logic [WALK_W-1:0] cells_walked;
		logic              overrun;
	} gls_out_t;

	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] waddr;
		logic [MAP_W-1:0] wdata;
		logic [ROW_W-1:0] raddr;
	} gls_ram_req_t;

endpackage

// File: rtl/core/gls_map_ram.sv
// ----------------------------------------------------------------------------
// gls_map_ram: walkability bitmap storage
// One row per entry, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module gls_map_ram (
	input  logic                           clk,
	input  gls_pkg::gls_ram_req_t          req,
	output logic [gls_pkg::MAP_W-1:0]      rdata
);
	import gls_pkg::*;

	logic [MAP_W-1:0] mem [MAP_SIDE];
	logic [MAP_W-1:0] rdata_q;

	// Write one row, read one row a cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/gls_walker.sv
// ----------------------------------------------------------------------------
// gls_walker: cell walk sequencer
// Loads map rows, and for a query steps cell by cell along the segment,
// reading one map row per check and comparing step times by cross products.
// ----------------------------------------------------------------------------
module gls_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         edge_blocked,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  gls_pkg::gls_in_t             in_data,
	output logic                         res_valid,
	input  logic                         res_take,
	output gls_pkg::gls_out_t            res_data,
	output gls_pkg::gls_ram_req_t        ram_req,
	input  logic [gls_pkg::MAP_W-1:0]    ram_rdata
);
	import gls_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RD       = 3'd1;
	localparam logic [2:0] ST_CHK      = 3'd2;
	localparam logic [2:0] ST_RD_SIDE  = 3'd3;
	localparam logic [2:0] ST_CHK_SIDE = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	localparam logic [1:0] MV_X = 2'd0;
	localparam logic [1:0] MV_Z = 2'd1;
	localparam logic [1:0] MV_C = 2'd2;

	function automatic logic cell_ok(input logic [POS_W-1:0] x, input logic [POS_W-1:0] z,
			input logic [MAP_W-1:0] row, input logic eb);
		logic in_map;
		in_map = !x[POS_W-1] && !z[POS_W-1] &&
			(x < POS_W'(MAP_SIDE)) && (z < POS_W'(MAP_SIDE));
		return in_map ? row[x[ROW_W-1:0]] : !eb;
	endfunction

	logic [2:0]         state_q;
	logic [POS_W-1:0]   cx_q, cz_q;
	logic [CELL_W-1:0]  x1_q, z1_q;
	logic [COORD_W-1:0] adx_q, adz_q;
	logic               sx_pos_q, sz_pos_q;
	logic [NDIST_W-1:0] nx_q, nz_q;
	logic [WALK_W-1:0]  bound_q, walked_q;
	logic [PROD_W-1:0]  tx_q, tz_q;
	logic               visible_q, overrun_q;

	// Query setup
	logic [CELL_W-1:0]  x0_c, z0_c, x1_c, z1_c, ddx_c, ddz_c;
	logic               dx_pos_c, dz_pos_c;
	logic [COORD_W-1:0] adx_c, adz_c;
	logic [NDIST_W-1:0] nx_init_c, nz_init_c;
	logic [WALK_W-1:0]  bound_c;

	always_comb begin
		x0_c     = in_data.start_x[COORD_W-1:FRAC_BITS];
		z0_c     = in_data.start_z[COORD_W-1:FRAC_BITS];
		x1_c     = in_data.end_x[COORD_W-1:FRAC_BITS];
		z1_c     = in_data.end_z[COORD_W-1:FRAC_BITS];
		dx_pos_c = in_data.end_x > in_data.start_x;
		dz_pos_c = in_data.end_z > in_data.start_z;
		adx_c    = dx_pos_c ? in_data.end_x - in_data.start_x : in_data.start_x - in_data.end_x;
		adz_c    = dz_pos_c ? in_data.end_z - in_data.start_z : in_data.start_z - in_data.end_z;
		nx_init_c = dx_pos_c ?
			NDIST_W'(FRAC_ONE) - NDIST_W'(in_data.start_x[FRAC_BITS-1:0]) :
			NDIST_W'(in_data.start_x[FRAC_BITS-1:0]);
		nz_init_c = dz_pos_c ?
			NDIST_W'(FRAC_ONE) - NDIST_W'(in_data.start_z[FRAC_BITS-1:0]) :
			NDIST_W'(in_data.start_z[FRAC_BITS-1:0]);
		ddx_c   = (x1_c >= x0_c) ? x1_c - x0_c : x0_c - x1_c;
		ddz_c   = (z1_c >= z0_c) ? z1_c - z0_c : z0_c - z1_c;
		bound_c = WALK_W'(ddx_c) + WALK_W'(ddz_c);
	end

	// Step decision
	logic [POS_W-1:0]   cx_nx, cz_nx;
	logic               cur_ok, at_end, side_x_ok, side_z_ok, over;
	logic [1:0]         which;
	logic [WALK_W:0]    walked_inc;

	always_comb begin
		cx_nx     = sx_pos_q ? cx_q + POS_W'(1) : cx_q - POS_W'(1);
		cz_nx     = sz_pos_q ? cz_q + POS_W'(1) : cz_q - POS_W'(1);
		cur_ok    = cell_ok(cx_q, cz_q, ram_rdata, edge_blocked);
		side_x_ok = cell_ok(cx_nx, cz_q, ram_rdata, edge_blocked);
		side_z_ok = cell_ok(cx_q, cz_nx, ram_rdata, edge_blocked);
		at_end    = (cx_q == POS_W'(x1_q)) && (cz_q == POS_W'(z1_q));
		if (adx_q == '0 && adz_q == '0) begin
			which = MV_C;
		end else if (adx_q == '0) begin
			which = MV_Z;
		end else if (adz_q == '0) begin
			which = MV_X;
		end else if (tx_q < tz_q) begin
			which = MV_X;
		end else if (tz_q < tx_q) begin
			which = MV_Z;
		end else begin
			which = MV_C;
		end
		walked_inc = {1'b0, walked_q} + ((which == MV_C) ? (WALK_W+1)'(2) : (WALK_W+1)'(1));
		over       = walked_inc > {1'b0, bound_q};
	end

	// Map port: rows are written only between items
	always_comb begin
		ram_req.we    = (state_q == ST_IDLE) && in_valid && (in_data.mode == MODE_WRITE) &&
			((ROW_IDX_W+1)'(in_data.map_row) < (ROW_IDX_W+1)'(MAP_SIDE));
		ram_req.waddr = in_data.map_row[ROW_W-1:0];
		ram_req.wdata = in_data.row_bits;
		ram_req.raddr = (state_q == ST_RD_SIDE) ? cz_nx[ROW_W-1:0] : cz_q[ROW_W-1:0];
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_data.mode == MODE_WRITE) ? ST_DONE : ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!cur_ok || at_end || over) begin
						state_q <= ST_DONE;
					end else if (which == MV_C) begin
						state_q <= side_x_ok ? ST_RD_SIDE : ST_DONE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD_SIDE: begin
					state_q <= ST_CHK_SIDE;
				end
				ST_CHK_SIDE: begin
					state_q <= side_z_ok ? ST_RD : ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q      <= POS_W'(x0_c);
				cz_q      <= POS_W'(z0_c);
				x1_q      <= x1_c;
				z1_q      <= z1_c;
				adx_q     <= adx_c;
				adz_q     <= adz_c;
				sx_pos_q  <= dx_pos_c;
				sz_pos_q  <= dz_pos_c;
				nx_q      <= nx_init_c;
				nz_q      <= nz_init_c;
				bound_q   <= (in_data.mode == MODE_WRITE) ? '0 : bound_c;
				walked_q  <= '0;
				visible_q <= 1'b0;
				overrun_q <= 1'b0;
			end
			ST_RD: begin
				tx_q <= PROD_W'(nx_q) * PROD_W'(adz_q);
				tz_q <= PROD_W'(nz_q) * PROD_W'(adx_q);
			end
			ST_CHK: begin
				if (cur_ok && at_end) begin
					visible_q <= 1'b1;
				end else if (cur_ok && over) begin
					overrun_q <= 1'b1;
				end else if (cur_ok && which == MV_X) begin
					cx_q     <= cx_nx;
					nx_q     <= nx_q + NDIST_W'(FRAC_ONE);
					walked_q <= walked_inc[WALK_W-1:0];
				end else if (cur_ok && which == MV_Z) begin
					cz_q     <= cz_nx;
					nz_q     <= nz_q + NDIST_W'(FRAC_ONE);
					walked_q <= walked_inc[WALK_W-1:0];
				end
			end
			ST_CHK_SIDE: begin
				if (side_z_ok) begin
					cx_q     <= cx_nx;
					cz_q     <= cz_nx;
					nx_q     <= nx_q + NDIST_W'(FRAC_ONE);
					nz_q     <= nz_q + NDIST_W'(FRAC_ONE);
					walked_q <= walked_q + WALK_W'(2);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_data  = '{visible: visible_q, cells_walked: walked_q, overrun: overrun_q};

	// Checks
	a_walk_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (walked_q <= bound_q))
		else $error("walk count passed the move bound");

	a_vis_not_over: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.visible && res_data.overrun))
		else $error("result both visible and overrun");

	a_side_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_SIDE) |=> (state_q == ST_CHK_SIDE))
		else $error("side row read not followed by its check");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q == ST_IDLE && in_data.mode == MODE_WRITE))
		else $error("map write outside an accepted write beat");

endmodule

// File: rtl/core/grid_line_of_sight.sv
// Timing: a row write passes through the done state and then the output register.
// A query reads and checks one map row per cell it visits; a corner move also reads and checks the side row.
// Throughput: one item at a time; each check waits on one map row read, and the
// output register lets the next item start while a result is still held.
// Reset: edge_blocked returns to 1 and the sequencer to idle; map rows are
// undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// grid_line_of_sight: grid line-of-sight unit
// Holds the configuration register and the output beat register around the
// map memory and the cell walk sequencer.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gls_pkg::gls_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output gls_pkg::gls_out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import gls_pkg::*;

	logic         edge_blocked_q;
	logic         res_valid, res_take;
	gls_out_t     res_data;
	gls_ram_req_t ram_req;
	logic [MAP_W-1:0] ram_rdata;
	logic         out_valid_q;
	gls_out_t     out_data_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_blocked_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			edge_blocked_q <= cfg_data;
		end
	end

	gls_map_ram u_map_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	gls_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.edge_blocked (edge_blocked_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res_data     (res_data),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata)
	);

	// Output beat register: load when empty or draining
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: tb/grid_line_of_sight_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_of_sight_tb: self-checking bench for the grid line-of-sight unit
// Loads the full walkability map, then sends directed and random row writes
// and sight queries under several idle and stall patterns. Each result beat
// is checked against an in-bench cell walk that uses exact integer crossing
// times, with the edge_blocked register flipped between phases.
// ----------------------------------------------------------------------------
module grid_line_of_sight_tb;
	import gls_pkg::*;

	typedef enum int {MOVE_X, MOVE_Z, MOVE_CORNER} move_e;

	localparam int IN_W = $bits(gls_in_t);

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	gls_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	gls_out_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic     cfg_data = 1'b1;

	// Predictor state: map rows and the edge mode
	logic [MAP_W-1:0] walk_rows [MAP_SIDE];
	bit               edge_blk = 1'b1;

	gls_in_t  pending_items [$];
	gls_out_t expected_sight [$];
	gls_out_t want_beat;

	int idle_pct = 0;
	int stall_pct = 0;
	int obst_k = 5;
	bit hold_send = 1'b0;

	int mismatches = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_visible = 0;
	int n_overrun = 0;
	int n_cfg = 0;

	grid_line_of_sight dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Append one item to the send queue
	function automatic void add_item(gls_in_t b);
		pending_items = {pending_items, b};
	endfunction

	// Cell walkability as seen by the walk, edge mode outside the map
	function automatic bit cell_open(int x, int z);
		if (x < 0 || z < 0 || x >= MAP_SIDE || z >= MAP_SIDE)
			return !edge_blk;
		return walk_rows[z][x] === 1'b1;
	endfunction

	// Apply one item to the map and walk the segment for a query
	function automatic gls_out_t predict_sight(gls_in_t b);
		gls_out_t res;
		longint   ax, az, bx, bz, dx, dz, adx, adz, nx, nz, tx, tz;
		int       x0, z0, x1, z1, cx, cz, sx, sz, walked, bound, inc;
		move_e    mv;
		bit       done;
		res = '0;
		if (b.mode == MODE_WRITE) begin
			if (b.map_row < MAP_SIDE)
				walk_rows[b.map_row] = b.row_bits;
			return res;
		end
		ax = longint'(b.start_x);
		az = longint'(b.start_z);
		bx = longint'(b.end_x);
		bz = longint'(b.end_z);
		x0 = int'(ax >>> FRAC_BITS);
		z0 = int'(az >>> FRAC_BITS);
		x1 = int'(bx >>> FRAC_BITS);
		z1 = int'(bz >>> FRAC_BITS);
		dx = bx - ax;
		dz = bz - az;
		adx = (dx < 0) ? -dx : dx;
		adz = (dz < 0) ? -dz : dz;
		sx = (dx > 0) ? 1 : -1;
		sz = (dz > 0) ? 1 : -1;
		// distance to the next cell boundary on each axis
		nx = (dx > 0) ? (longint'(x0) + 1) * FRAC_ONE - ax : ax - longint'(x0) * FRAC_ONE;
		nz = (dz > 0) ? (longint'(z0) + 1) * FRAC_ONE - az : az - longint'(z0) * FRAC_ONE;
		bound = ((x1 > x0) ? x1 - x0 : x0 - x1) + ((z1 > z0) ? z1 - z0 : z0 - z1);
		cx = x0;
		cz = z0;
		walked = 0;
		done = 1'b0;
		while (!done) begin
			if (!cell_open(cx, cz)) begin
				done = 1'b1;
			end else if (cx == x1 && cz == z1) begin
				res.visible = 1'b1;
				done = 1'b1;
			end else begin
				// pick the axis whose boundary comes first, a tie is a corner
				if (adx == 0 && adz == 0) mv = MOVE_CORNER;
				else if (adx == 0) mv = MOVE_Z;
				else if (adz == 0) mv = MOVE_X;
				else begin
					tx = nx * adz;
					tz = nz * adx;
					mv = (tx < tz) ? MOVE_X : ((tz < tx) ? MOVE_Z : MOVE_CORNER);
				end
				inc = (mv == MOVE_CORNER) ? 2 : 1;
				if (walked + inc > bound) begin
					res.overrun = 1'b1;
					done = 1'b1;
				end else if (mv == MOVE_CORNER &&
						(!cell_open(cx + sx, cz) || !cell_open(cx, cz + sz))) begin
					done = 1'b1;
				end else begin
					if (mv != MOVE_Z) begin
						cx += sx;
						nx += FRAC_ONE;
					end
					if (mv != MOVE_X) begin
						cz += sz;
						nz += FRAC_ONE;
					end
					walked += inc;
				end
			end
		end
		res.cells_walked = (walked > 255) ? 8'd255 : walked[7:0];
		return res;
	endfunction

	// Row with obstacles on roughly one cell in 2**k
	function automatic logic [MAP_W-1:0] rand_row(int k);
		logic [MAP_W-1:0] blocked;
		blocked = '1;
		repeat (k) blocked &= {$urandom, $urandom};
		return ~blocked;
	endfunction

	function automatic gls_in_t row_item(int r, logic [MAP_W-1:0] bits);
		gls_in_t b;
		b = IN_W'({$urandom, $urandom, $urandom, $urandom});
		b.mode = MODE_WRITE;
		b.map_row = r[ROW_IDX_W-1:0];
		b.row_bits = bits;
		return b;
	endfunction

	function automatic gls_in_t query(int ax, int az, int bx, int bz);
		gls_in_t b;
		b = IN_W'({$urandom, $urandom, $urandom, $urandom});
		b.mode = MODE_QUERY;
		b.start_x = ax[COORD_W-1:0];
		b.start_z = az[COORD_W-1:0];
		b.end_x = bx[COORD_W-1:0];
		b.end_z = bz[COORD_W-1:0];
		return b;
	endfunction

	// Random query: mostly short hops, some snapped to boundaries or diagonal
	function automatic gls_in_t rand_query();
		int c [4];
		int d;
		c[0] = $urandom_range(16383, 0);
		c[1] = $urandom_range(16383, 0);
		for (int i = 2; i < 4; i++) begin
			if ($urandom_range(99, 0) < 60)
				c[i] = c[i-2] + int'($urandom_range(4096, 0)) - 2048;
			else
				c[i] = $urandom_range(16383, 0);
			if (c[i] < 0) c[i] = 0;
			if (c[i] > 16383) c[i] = 16383;
		end
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(99, 0) < 20) c[i] &= ~(FRAC_ONE - 1);
			if ($urandom_range(99, 0) < 3) c[i] = $urandom_range(1, 0) ? 16383 : 0;
		end
		if ($urandom_range(99, 0) < 15) begin
			d = c[2] - c[0];
			d = $urandom_range(1, 0) ? d : -d;
			if (c[1] + d >= 0 && c[1] + d <= 16383) c[3] = c[1] + d;
		end
		return query(c[0], c[1], c[2], c[3]);
	endfunction

	function automatic gls_in_t rand_item();
		if ($urandom_range(99, 0) < 12)
			return row_item($urandom_range(MAP_SIDE - 1, 0), rand_row(obst_k));
		return rand_query();
	endfunction

	// Driver: advance to the next beat once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (!hold_send && pending_items.size() != 0 &&
					$urandom_range(99, 0) >= idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: predict on input beats, check output beats, drive stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (in_data.mode == MODE_WRITE) n_writes++;
				else n_queries++;
				expected_sight = {expected_sight, predict_sight(in_data)};
			end
			if (out_valid && !out_stall) begin
				if (expected_sight.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: vis=%0d walked=%0d ovr=%0d",
							out_data.visible, out_data.cells_walked, out_data.overrun);
				end else begin
					want_beat = expected_sight.pop_front();
					if (want_beat.visible) n_visible++;
					if (want_beat.overrun) n_overrun++;
					if (out_data.visible !== want_beat.visible ||
							out_data.cells_walked !== want_beat.cells_walked ||
							out_data.overrun !== want_beat.overrun) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp vis=%0d walked=%0d ovr=%0d, got vis=%0d walked=%0d ovr=%0d",
								want_beat.visible, want_beat.cells_walked, want_beat.overrun,
								out_data.visible, out_data.cells_walked, out_data.overrun);
					end
				end
			end
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	// Hold until no beat is in flight and every result has arrived
	task automatic wait_quiet(input bit with_pending);
		do @(negedge clk);
		while ((with_pending && pending_items.size() != 0) || in_valid ||
				expected_sight.size() != 0);
	endtask

	task automatic write_edge_mode(input bit v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		edge_blk = v;
		n_cfg++;
	endtask

	task automatic run_phase(input int n, input int idle, input int stall, input int k);
		idle_pct = idle;
		stall_pct = stall;
		obst_k = k;
		repeat (n) add_item(rand_item());
		wait_quiet(1'b1);
	endtask

	// Stimulus sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_edge_mode(1'b1);

		// load every row before any query can read one
		for (int r = 0; r < MAP_SIDE; r++)
			add_item(row_item(r, rand_row(5)));
		wait_quiet(1'b1);

		// directed: field extremes, ties, blocked rows, overshoot
		add_item(row_item(0, '1));
		add_item(row_item(63, '1));
		add_item(row_item(10, '0));
		add_item(row_item(11, {32{2'b01}}));
		add_item(query(0, 0, 0, 0));
		add_item(query(0, 0, 16383, 0));
		add_item(query(16383, 16383, 0, 16383));
		add_item(query(0, 0, 16383, 16383));
		add_item(query(16383, 0, 0, 16383));
		add_item(query(128, 9 * 256 + 128, 640, 11 * 256 + 128));
		add_item(query(300, 11 * 256 + 20, 2000, 11 * 256 + 200));
		add_item(query(300, 10 * 256 + 5, 300, 10 * 256 + 5));
		add_item(query(1000, 600, 512, 768));
		add_item(query(300, 100, 0, 256));
		add_item(query(512, 512, 100, 100));
		add_item(query(5 * 256 + 7, 0, 5 * 256 + 7, 16383));
		add_item(query(100, 100, 512, 100));
		add_item(query(16383, 16383, 16383, 16383));
		wait_quiet(1'b1);

		// open map, no idling, with one full drain in the middle
		write_edge_mode(1'b0);
		idle_pct = 0;
		stall_pct = 0;
		obst_k = 6;
		repeat (180) add_item(rand_item());
		do @(negedge clk); while (pending_items.size() > 90);
		hold_send = 1'b1;
		wait_quiet(1'b0);
		hold_send = 1'b0;
		wait_quiet(1'b1);

		write_edge_mode(1'b1);
		run_phase(170, 88, 0, 4);
		write_edge_mode(1'b0);
		run_phase(170, 0, 88, 2);
		write_edge_mode(1'b1);
		run_phase(180, 6, 6, 5);

		// let any stray beat show up
		stall_pct = 0;
		repeat (300) @(posedge clk);

		$display("covered %0d row writes and %0d queries (%0d visible, %0d overrun), %0d edge mode writes",
			n_writes, n_queries, n_visible, n_overrun, n_cfg);
		$display("idle patterns: none, sender 88%%, receiver 88%%, both 6%%; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#25000000;
		$display("timeout with %0d results outstanding", expected_sight.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
